@@ rtl/spa_pkg.sv @@
package spa_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD_A = 2'd0,
        REQ_LOAD_B = 2'd1,
        REQ_ADD    = 2'd2
    } t_req;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } t_state;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic more;
    } t_status;

endpackage

@@ rtl/spa_ram.sv @@
module spa_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/spa_ctrl.sv @@
module spa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [1:0]      i_req_type,
    input  spa_pkg::t_status i_status,
    output spa_pkg::t_cmd   o_cmd,
    output logic            busy
);

    spa_pkg::t_state r_state;
    spa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            spa_pkg::ST_IDLE: begin
                if (start) begin
                    case (i_req_type)
                        spa_pkg::REQ_LOAD_A: o_cmd.load_a = 1'b1;
                        spa_pkg::REQ_LOAD_B: o_cmd.load_b = 1'b1;
                        spa_pkg::REQ_ADD:    n_state = spa_pkg::ST_MERGE;
                        default:             n_state = spa_pkg::ST_IDLE;
                    endcase
                end
            end
            spa_pkg::ST_MERGE: begin
                if (i_status.more) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = spa_pkg::ST_IDLE;
                end
            end
            default: n_state = spa_pkg::ST_IDLE;
        endcase
    end

    assign busy = (r_state == spa_pkg::ST_MERGE);

endmodule

@@ rtl/spa_datapath.sv @@
module spa_datapath #(
    parameter int MAX_TERMS  = 32,
    parameter int COEF_WIDTH = 24,
    parameter int EXP_WIDTH  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  spa_pkg::t_cmd                i_cmd,
    input  logic signed [COEF_WIDTH-1:0] i_term_coef,
    input  logic signed [EXP_WIDTH-1:0]  i_term_exp,
    output spa_pkg::t_status             o_status,
    output logic                         o_valid,
    output logic signed [COEF_WIDTH-1:0] o_sum_coef,
    output logic signed [EXP_WIDTH-1:0]  o_sum_exp,
    output logic                         o_last_term,
    output logic                         o_empty_sum,
    output logic                         o_terms_dropped
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int TW = COEF_WIDTH + EXP_WIDTH;
    localparam logic [CW-1:0] FULL = CW'(MAX_TERMS);
    localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

    logic [CW-1:0] r_cnt_a, r_cnt_b, r_i, r_j;
    logic [CW-1:0] n_i, n_j;
    logic          r_ovf;
    logic          we_a, we_b;
    logic [TW-1:0] rd_a, rd_b;

    logic signed [COEF_WIDTH-1:0] coef_a, coef_b;
    logic signed [EXP_WIDTH-1:0]  exp_a, exp_b;
    logic                         a_ok, b_ok, eq, take_a;
    logic signed [COEF_WIDTH:0]   sum_w;
    logic signed [COEF_WIDTH-1:0] sum_sat;
    logic signed [COEF_WIDTH-1:0] cand_coef;
    logic signed [EXP_WIDTH-1:0]  cand_exp;
    logic                         cand_keep;

    logic                         r_pend_vld;
    logic signed [COEF_WIDTH-1:0] r_pend_coef;
    logic signed [EXP_WIDTH-1:0]  r_pend_exp;

    logic                         r_out_vld;
    logic signed [COEF_WIDTH-1:0] r_out_coef;
    logic signed [EXP_WIDTH-1:0]  r_out_exp;
    logic                         r_out_last, r_out_empty, r_out_drop;

    assign we_a = i_cmd.load_a && (r_cnt_a != FULL);
    assign we_b = i_cmd.load_b && (r_cnt_b != FULL);

    spa_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata ({i_term_coef, i_term_exp}),
        .i_raddr (n_i[AW-1:0]),
        .o_rdata (rd_a)
    );

    spa_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata ({i_term_coef, i_term_exp}),
        .i_raddr (n_j[AW-1:0]),
        .o_rdata (rd_b)
    );

    always_comb begin
        coef_a = rd_a[TW-1:EXP_WIDTH];
        exp_a  = rd_a[EXP_WIDTH-1:0];
        coef_b = rd_b[TW-1:EXP_WIDTH];
        exp_b  = rd_b[EXP_WIDTH-1:0];
        a_ok   = (r_i < r_cnt_a);
        b_ok   = (r_j < r_cnt_b);
        eq     = a_ok && b_ok && (exp_a == exp_b);
        take_a = !eq && (!b_ok || (a_ok && (exp_a > exp_b)));

        sum_w = {coef_a[COEF_WIDTH-1], coef_a} + {coef_b[COEF_WIDTH-1], coef_b};
        if (sum_w[COEF_WIDTH] != sum_w[COEF_WIDTH-1]) begin
            sum_sat = sum_w[COEF_WIDTH] ? COEF_MIN : COEF_MAX;
        end else begin
            sum_sat = sum_w[COEF_WIDTH-1:0];
        end

        if (eq) begin
            cand_coef = sum_sat;
            cand_exp  = exp_a;
            cand_keep = (sum_sat != '0);
        end else if (take_a) begin
            cand_coef = coef_a;
            cand_exp  = exp_a;
            cand_keep = 1'b1;
        end else begin
            cand_coef = coef_b;
            cand_exp  = exp_b;
            cand_keep = 1'b1;
        end

        n_i = r_i;
        n_j = r_j;
        if (i_cmd.finish) begin
            n_i = '0;
            n_j = '0;
        end else if (i_cmd.step) begin
            if (eq || take_a) begin
                n_i = CW'(r_i + 1'b1);
            end
            if (eq || !take_a) begin
                n_j = CW'(r_j + 1'b1);
            end
        end
    end

    assign o_status.more = a_ok || b_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_ovf      <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_i       <= n_i;
            r_j       <= n_j;
            r_out_vld <= 1'b0;
            if (i_cmd.load_a) begin
                if (we_a) begin
                    r_cnt_a <= CW'(r_cnt_a + 1'b1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.load_b) begin
                if (we_b) begin
                    r_cnt_b <= CW'(r_cnt_b + 1'b1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.step && cand_keep) begin
                r_out_vld  <= r_pend_vld;
                r_pend_vld <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_vld  <= 1'b1;
                r_pend_vld <= 1'b0;
                r_cnt_a    <= '0;
                r_cnt_b    <= '0;
                r_ovf      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && cand_keep) begin
            r_pend_coef <= cand_coef;
            r_pend_exp  <= cand_exp;
            r_out_coef  <= r_pend_coef;
            r_out_exp   <= r_pend_exp;
            r_out_last  <= 1'b0;
            r_out_empty <= 1'b0;
            r_out_drop  <= r_ovf;
        end else if (i_cmd.finish) begin
            r_out_coef  <= r_pend_vld ? r_pend_coef : '0;
            r_out_exp   <= r_pend_vld ? r_pend_exp : '0;
            r_out_last  <= 1'b1;
            r_out_empty <= !r_pend_vld;
            r_out_drop  <= r_ovf;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_sum_coef      = r_out_coef;
    assign o_sum_exp       = r_out_exp;
    assign o_last_term     = r_out_last;
    assign o_empty_sum     = r_out_empty;
    assign o_terms_dropped = r_out_drop;

endmodule

@@ rtl/sparse_polynomial_add.sv @@
// Load words leave busy low, so the next word may follow at once.
// An add keeps busy high through its merge steps and a closing step,
// where the number of merge steps lies between the larger and the sum of the two term counts.
// Result words leave at most one per cycle, each held back until the next kept
// term or the closing cycle sets its last mark; the final word is valid in the same cycle that busy falls.
// Results never stall; synchronous active-low reset empties both stores, clears the drop flag.
module sparse_polynomial_add #(
    parameter int MAX_TERMS  = 32,
    parameter int COEF_WIDTH = 24,
    parameter int EXP_WIDTH  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_req_type,
    input  logic signed [COEF_WIDTH-1:0] i_term_coef,
    input  logic signed [EXP_WIDTH-1:0]  i_term_exp,
    output logic                         o_valid,
    output logic signed [COEF_WIDTH-1:0] o_sum_coef,
    output logic signed [EXP_WIDTH-1:0]  o_sum_exp,
    output logic                         o_last_term,
    output logic                         o_empty_sum,
    output logic                         o_terms_dropped
);

    spa_pkg::t_cmd    cmd;
    spa_pkg::t_status status;

    spa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    spa_datapath #(
        .MAX_TERMS  (MAX_TERMS),
        .COEF_WIDTH (COEF_WIDTH),
        .EXP_WIDTH  (EXP_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_term_coef     (i_term_coef),
        .i_term_exp      (i_term_exp),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_sum_coef      (o_sum_coef),
        .o_sum_exp       (o_sum_exp),
        .o_last_term     (o_last_term),
        .o_empty_sum     (o_empty_sum),
        .o_terms_dropped (o_terms_dropped)
    );

endmodule

@@ tb/tb_top.sv @@
module tb_top;

    localparam int MAX_TERMS  = 32;
    localparam int COEF_WIDTH = 24;
    localparam int EXP_WIDTH  = 16;
    localparam int COEF_MAX   = (1 << (COEF_WIDTH - 1)) - 1;
    localparam int COEF_MIN   = -(1 << (COEF_WIDTH - 1));
    localparam int EXP_MAX    = (1 << (EXP_WIDTH - 1)) - 1;
    localparam int EXP_MIN    = -(1 << (EXP_WIDTH - 1));

    typedef logic signed [COEF_WIDTH-1:0] t_coef;
    typedef logic signed [EXP_WIDTH-1:0]  t_expo;

    typedef struct {
        t_coef coef;
        t_expo expo;
        logic  last_term;
        logic  empty_sum;
        logic  terms_dropped;
    } t_sum_term;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_req_type;
    t_coef       i_term_coef;
    t_expo       i_term_exp;
    logic        o_valid;
    t_coef       o_sum_coef;
    t_expo       o_sum_exp;
    logic        o_last_term;
    logic        o_empty_sum;
    logic        o_terms_dropped;

    t_coef       poly_a_coef [MAX_TERMS];
    t_expo       poly_a_expo [MAX_TERMS];
    t_coef       poly_b_coef [MAX_TERMS];
    t_expo       poly_b_expo [MAX_TERMS];
    int          poly_a_count;
    int          poly_b_count;
    logic        dropped_seen;

    t_sum_term   sum_terms_due[$];
    int          fail_count;
    int          words_sent;
    int          sender_idle_pct;

    sparse_polynomial_add #(
        .MAX_TERMS  (MAX_TERMS),
        .COEF_WIDTH (COEF_WIDTH),
        .EXP_WIDTH  (EXP_WIDTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_term_coef     (i_term_coef),
        .i_term_exp      (i_term_exp),
        .o_valid         (o_valid),
        .o_sum_coef      (o_sum_coef),
        .o_sum_exp       (o_sum_exp),
        .o_last_term     (o_last_term),
        .o_empty_sum     (o_empty_sum),
        .o_terms_dropped (o_terms_dropped)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_sum_term make_term(t_coef coef, t_expo expo, logic empty_sum);
        t_sum_term term;
        term.coef          = coef;
        term.expo          = expo;
        term.last_term     = 1'b0;
        term.empty_sum     = empty_sum;
        term.terms_dropped = dropped_seen;
        return term;
    endfunction

    task automatic predict_word(spa_pkg::t_req req, t_coef coef, t_expo expo);
        t_sum_term job[$];
        int        i;
        int        j;
        int        sum;
        i = 0;
        j = 0;
        case (req)
            spa_pkg::REQ_LOAD_A: begin
                if (poly_a_count >= MAX_TERMS) begin
                    dropped_seen = 1'b1;
                end else begin
                    poly_a_coef[poly_a_count] = coef;
                    poly_a_expo[poly_a_count] = expo;
                    poly_a_count++;
                end
            end
            spa_pkg::REQ_LOAD_B: begin
                if (poly_b_count >= MAX_TERMS) begin
                    dropped_seen = 1'b1;
                end else begin
                    poly_b_coef[poly_b_count] = coef;
                    poly_b_expo[poly_b_count] = expo;
                    poly_b_count++;
                end
            end
            spa_pkg::REQ_ADD: begin
                while (i < poly_a_count || j < poly_b_count) begin
                    if (i < poly_a_count && j < poly_b_count &&
                        poly_a_expo[i] == poly_b_expo[j]) begin
                        sum = int'(poly_a_coef[i]) + int'(poly_b_coef[j]);
                        if (sum > COEF_MAX) begin
                            sum = COEF_MAX;
                        end else if (sum < COEF_MIN) begin
                            sum = COEF_MIN;
                        end
                        if (sum != 0) begin
                            job.push_back(make_term(t_coef'(sum), poly_a_expo[i], 1'b0));
                        end
                        i++;
                        j++;
                    end else if (j >= poly_b_count ||
                                 (i < poly_a_count && poly_a_expo[i] > poly_b_expo[j])) begin
                        job.push_back(make_term(poly_a_coef[i], poly_a_expo[i], 1'b0));
                        i++;
                    end else begin
                        job.push_back(make_term(poly_b_coef[j], poly_b_expo[j], 1'b0));
                        j++;
                    end
                end
                if (job.size() == 0) begin
                    job.push_back(make_term('0, '0, 1'b1));
                end
                job[job.size()-1].last_term = 1'b1;
                foreach (job[k]) sum_terms_due.push_back(job[k]);
                poly_a_count = 0;
                poly_b_count = 0;
                dropped_seen = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_word(spa_pkg::t_req req, t_coef coef, t_expo expo);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_req_type  <= req;
        i_term_coef <= coef;
        i_term_exp  <= expo;
        do @(posedge i_clk); while (busy !== 1'b0);
        words_sent++;
        predict_word(req, coef, expo);
    endtask

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_sum_term want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (sum_terms_due.size() == 0) begin
                $display("%0t: unexpected result word expected none got coef %0d exp %0d",
                         $time, o_sum_coef, o_sum_exp);
                fail_count++;
            end else begin
                want = sum_terms_due.pop_front();
                check_field("sum_coef", want.coef, o_sum_coef);
                check_field("sum_exp", want.expo, o_sum_exp);
                check_field("last_term", want.last_term, o_last_term);
                check_field("empty_sum", want.empty_sum, o_empty_sum);
                check_field("terms_dropped", want.terms_dropped, o_terms_dropped);
            end
        end
    end

    function automatic t_coef rand_coef();
        case ($urandom_range(9))
            0:       return t_coef'(COEF_MAX);
            1:       return t_coef'(COEF_MIN);
            2:       return t_coef'(int'($urandom_range(255)) - 128);
            default: return t_coef'($urandom());
        endcase
    endfunction

    function automatic int pick_count();
        if ($urandom_range(6) == 0) return $urandom_range(7, 16);
        return $urandom_range(0, 6);
    endfunction

    task automatic run_job(int na, int nb, bit ordered);
        t_coef a_c[$];
        t_coef b_c[$];
        t_expo a_e[$];
        t_expo b_e[$];
        int    cur;
        int    pick;
        t_coef c;
        cur = ($urandom_range(7) == 0) ? EXP_MAX : int'($urandom_range(65535)) + EXP_MIN;
        while (a_c.size() < na || b_c.size() < nb) begin
            pick = $urandom_range(2);
            if (a_c.size() >= na) begin
                pick = 1;
            end else if (b_c.size() >= nb) begin
                pick = 0;
            end
            c = rand_coef();
            if (pick != 1) begin
                a_c.push_back(c);
                a_e.push_back(t_expo'(cur));
            end
            if (pick != 0) begin
                b_c.push_back((pick == 2 && $urandom_range(2) == 0) ? -c : rand_coef());
                b_e.push_back(t_expo'(cur));
            end
            cur = ordered ? cur - int'($urandom_range(1, 3)) : int'($urandom_range(8)) - 4;
        end
        while (a_c.size() != 0 || b_c.size() != 0) begin
            if (b_c.size() == 0 || (a_c.size() != 0 && $urandom_range(1) == 0)) begin
                send_word(spa_pkg::REQ_LOAD_A, a_c.pop_front(), a_e.pop_front());
            end else begin
                send_word(spa_pkg::REQ_LOAD_B, b_c.pop_front(), b_e.pop_front());
            end
        end
        send_word(spa_pkg::REQ_ADD, t_coef'($urandom()), t_expo'($urandom()));
    endtask

    task automatic test_empty_sum();
        send_word(spa_pkg::REQ_ADD, '0, '0);
        send_word(spa_pkg::REQ_LOAD_A, t_coef'(24'h001234), t_expo'(3));
        send_word(spa_pkg::REQ_LOAD_B, t_coef'(-24'sh001234), t_expo'(3));
        send_word(spa_pkg::REQ_ADD, '0, '0);
    endtask

    task automatic test_saturation();
        send_word(spa_pkg::REQ_LOAD_A, t_coef'(COEF_MAX), t_expo'(EXP_MAX));
        send_word(spa_pkg::REQ_LOAD_B, t_coef'(COEF_MAX), t_expo'(EXP_MAX));
        send_word(spa_pkg::REQ_LOAD_A, '0, t_expo'(50));
        send_word(spa_pkg::REQ_LOAD_A, t_coef'(256), t_expo'(-1));
        send_word(spa_pkg::REQ_LOAD_B, t_coef'(-256), t_expo'(-1));
        send_word(spa_pkg::REQ_LOAD_A, t_coef'(COEF_MIN), t_expo'(EXP_MIN));
        send_word(spa_pkg::REQ_LOAD_B, t_coef'(COEF_MIN), t_expo'(EXP_MIN));
        send_word(spa_pkg::REQ_ADD, '0, '0);
    endtask

    task automatic test_unordered();
        send_word(spa_pkg::REQ_LOAD_A, t_coef'(1), t_expo'(1));
        send_word(spa_pkg::REQ_LOAD_A, t_coef'(2), t_expo'(5));
        send_word(spa_pkg::REQ_LOAD_B, t_coef'(4), t_expo'(5));
        send_word(spa_pkg::REQ_LOAD_A, t_coef'(3), t_expo'(-2));
        send_word(spa_pkg::REQ_LOAD_B, t_coef'(5), t_expo'(0));
        send_word(spa_pkg::REQ_ADD, '0, '0);
    endtask

    task automatic test_one_sided();
        send_word(spa_pkg::REQ_LOAD_B, t_coef'(7), t_expo'(-3));
        send_word(spa_pkg::REQ_LOAD_B, t_coef'(-8), t_expo'(-4));
        send_word(spa_pkg::REQ_ADD, '0, '0);
        send_word(spa_pkg::REQ_LOAD_A, t_coef'(COEF_MIN), '0);
        send_word(spa_pkg::REQ_ADD, '1, '1);
    endtask

    task automatic test_random(int idle_pct, int budget);
        int first_word;
        sender_idle_pct = idle_pct;
        first_word      = words_sent;
        run_job($urandom_range(33, 36), $urandom_range(28, 34), 1'b1);
        while (words_sent - first_word < budget) begin
            run_job(pick_count(), pick_count(), $urandom_range(6) != 0);
        end
    endtask

    initial begin
        poly_a_count    = 0;
        poly_b_count    = 0;
        dropped_seen    = 1'b0;
        fail_count      = 0;
        words_sent      = 0;
        sender_idle_pct = 23;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req_type  <= spa_pkg::REQ_LOAD_A;
        i_term_coef <= '0;
        i_term_exp  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_sum();
        test_saturation();
        test_unordered();
        test_one_sided();
        test_random(23, 115);
        test_random(56, 115);
        test_random(0, 112);

        start <= 1'b0;
        while (sum_terms_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
